// ===== rtl/dogex_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dogex_pkg
// Shared widths, register indexes, defaults and the queue entry type of the
// scale-space extremum detector.
// ----------------------------------------------------------------------------
package dogex_pkg;

  // result position widths
  localparam int ROW_W = 12;
  localparam int COL_W = 11;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;
  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int THR_W      = 23;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONTRAST_THRESHOLD = 2'd2;

  localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 12'd640;
  localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST = 13'd480;
  localparam logic [THR_W-1:0] THRESHOLD_RST    = 23'd1;

  localparam logic [FH_W-1:0] MAX_HEIGHT = 13'd4096;

  // parameter defaults
  localparam int MAX_WIDTH_DEF   = 2048;
  localparam int SAMPLE_BITS_DEF = 24;

  // decision queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one decided input: the position of that input and up to four decisions,
  // indexed {row is the later row, column is the later column}
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             r_ge1;
    logic             c_ge1;
    logic             last_r;
    logic             last_c;
    logic [3:0]       key;
    logic [3:0]       maxi;
  } entry_t;

endpackage

// ===== rtl/dogex_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dogex_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dogex_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/dogex_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dogex_queue
// Short FIFO of decided inputs between the front and the back.
// ----------------------------------------------------------------------------
module dogex_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  dogex_pkg::entry_t            push_entry,
  input  logic                         pop,
  output dogex_pkg::entry_t            head,
  output logic [dogex_pkg::QCNT_W-1:0] count
);

  localparam int DEPTH = dogex_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  dogex_pkg::entry_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // the front reserves room before it takes an item
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < dogex_pkg::QCNT_W'(DEPTH)))
    else $error("decision queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("decision queue read while empty");

endmodule

// ===== rtl/dogex_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dogex_back
// Expands each queued entry into its one to four results, in row then
// column order, through an output register.
// ----------------------------------------------------------------------------
module dogex_back (
  input  logic                          clk,
  input  logic                          rst,
  input  dogex_pkg::entry_t             head,
  input  logic [dogex_pkg::QCNT_W-1:0]  count,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dogex_pkg::ROW_W-1:0]   pixel_row,
  output logic [dogex_pkg::COL_W-1:0]   pixel_col,
  output logic                          is_keypoint,
  output logic                          is_maximum,
  output logic                          last_of_run,
  output logic                          frame_done
);

  logic head_valid;
  logic load;
  logic ri;     // second row of the run
  logic cj;     // second column of the run
  logic rsel;   // decided row is the later row
  logic csel;
  logic last_i;
  logic last_j;
  logic last_res;
  logic [1:0] k;

  assign head_valid = (count != '0);
  assign load       = head_valid && (!out_valid || !out_stall);

  always_comb begin
    rsel     = ri || !head.r_ge1;
    csel     = cj || !head.c_ge1;
    last_i   = (ri == (head.r_ge1 && head.last_r));
    last_j   = (cj == (head.c_ge1 && head.last_c));
    last_res = last_i && last_j;
    k        = {rsel, csel};
    pop      = load && last_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ri        <= 1'b0;
      cj        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        if (!last_j) begin
          cj <= 1'b1;
        end else begin
          cj <= 1'b0;
          ri <= !last_i;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_row   <= rsel ? head.row : head.row - 1'b1;
      pixel_col   <= csel ? head.col : head.col - 1'b1;
      is_keypoint <= head.key[k];
      is_maximum  <= head.maxi[k];
      last_of_run <= last_res;
      frame_done  <= rsel && csel && head.last_r && head.last_c;
    end
  end

  a_pop_ends_run: assert property (@(posedge clk) disable iff (rst)
    pop |=> (out_valid && last_of_run))
    else $error("entry released before its last result");

  a_frame_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_done) |-> last_of_run)
    else $error("frame end not on the last result of its run");

endmodule

// ===== rtl/dogex_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dogex_front
// Takes pixel transfers, tracks the raster position, keeps two rows of each
// layer in the line store, shifts the 3x3x3 window and decides the up to
// four pixels each input settles, then queues the decisions.
// ----------------------------------------------------------------------------
module dogex_front #(
  parameter int MAX_WIDTH   = dogex_pkg::MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = dogex_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [dogex_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dogex_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [SAMPLE_BITS-1:0]    dog_below,
  input  logic signed [SAMPLE_BITS-1:0]    dog_here,
  input  logic signed [SAMPLE_BITS-1:0]    dog_above,
  input  logic [dogex_pkg::QCNT_W-1:0]     q_count,
  output logic                             push,
  output dogex_pkg::entry_t                push_entry
);

  localparam int SB = SAMPLE_BITS;
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int LW = 2 * SB;
  localparam int WW = 3 * LW;
  localparam int MW = ((SB > dogex_pkg::THR_W) ? SB : dogex_pkg::THR_W) + 1;
  localparam int CW = dogex_pkg::COL_W;
  localparam int RW = dogex_pkg::ROW_W;
  localparam int FW = dogex_pkg::FW_W;
  localparam int FH = dogex_pkg::FH_W;
  localparam int QW = dogex_pkg::QCNT_W;
  localparam int MAXC_I = (MAX_WIDTH - 1 < (1 << CW) - 1) ? MAX_WIDTH - 1 : (1 << CW) - 1;
  localparam int MAXW_I = (MAX_WIDTH < (1 << FW) - 1) ? MAX_WIDTH : (1 << FW) - 1;
  localparam logic [CW-1:0] MAXC = CW'(MAXC_I);
  localparam logic [FW-1:0] MAXW = FW'(MAXW_I);

  typedef struct packed {
    logic [RW-1:0] row;
    logic [CW-1:0] col;
    logic          r_ge1;
    logic          r_ge2;
    logic          c_ge1;
    logic          c_ge2;
    logic          last_r;
    logic          last_c;
  } pos_t;

  // configuration
  logic [FW-1:0]                frame_width;
  logic [FH-1:0]                frame_height;
  logic [dogex_pkg::THR_W-1:0]  contrast_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width        <= dogex_pkg::FRAME_WIDTH_RST;
      frame_height       <= dogex_pkg::FRAME_HEIGHT_RST;
      contrast_threshold <= dogex_pkg::THRESHOLD_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        dogex_pkg::REG_FRAME_WIDTH:        frame_width        <= cfg_data[FW-1:0];
        dogex_pkg::REG_FRAME_HEIGHT:       frame_height       <= cfg_data[FH-1:0];
        dogex_pkg::REG_CONTRAST_THRESHOLD: contrast_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: accept and classify
  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [CW-1:0] c_eff;
  logic [FW-1:0] w_eff;
  logic [FH-1:0] h_eff;
  logic          last_c;
  logic          last_r;
  logic [QW:0]   credit;
  logic          accept;
  logic [AW-1:0] raddr;

  logic          s1_valid;
  pos_t          s1_pos;
  logic [AW-1:0] s1_addr;
  logic signed [SB-1:0] s1_samp [3];
  logic          s1_byp;
  logic [WW-1:0] s1_byp_data;

  logic          s2_valid;
  pos_t          s2_pos;

  logic [WW-1:0] rdata;
  logic [WW-1:0] word;
  logic [WW-1:0] wdata;
  logic signed [SB-1:0] top [3];
  logic signed [SB-1:0] mid [3];
  logic signed [SB-1:0] win [3][3][3];

  always_comb begin
    c_eff  = (col > MAXC) ? MAXC : col;
    w_eff  = (frame_width == '0) ? FW'(1) : ((frame_width > MAXW) ? MAXW : frame_width);
    h_eff  = (frame_height == '0) ? FH'(1) :
             ((frame_height > dogex_pkg::MAX_HEIGHT) ? dogex_pkg::MAX_HEIGHT : frame_height);
    last_c = ({{(FW-CW){1'b0}}, c_eff} >= (w_eff - 1'b1));
    last_r = ({{(FH-RW){1'b0}}, row} >= (h_eff - 1'b1));
    raddr  = AW'(c_eff);
    // room is reserved for every item still in the pipe
    credit   = {1'b0, q_count} + (QW+1)'(s1_valid) + (QW+1)'(s2_valid);
    in_stall = (credit >= (QW+1)'(dogex_pkg::QUEUE_DEPTH));
    accept   = in_valid && !in_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= '0;
      col      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (last_c) begin
          col <= '0;
          row <= last_r ? '0 : row + 1'b1;
        end else begin
          col <= c_eff + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos.row    <= row;
      s1_pos.col    <= c_eff;
      s1_pos.r_ge1  <= (row != '0);
      s1_pos.r_ge2  <= (row > RW'(1));
      s1_pos.c_ge1  <= (c_eff != '0);
      s1_pos.c_ge2  <= (c_eff > CW'(1));
      s1_pos.last_r <= last_r;
      s1_pos.last_c <= last_c;
      s1_addr       <= raddr;
      s1_samp[0]    <= dog_below;
      s1_samp[1]    <= dog_here;
      s1_samp[2]    <= dog_above;
      // same column written back this cycle (one-pixel rows)
      s1_byp        <= s1_valid && (s1_addr == raddr);
      s1_byp_data   <= wdata;
    end
  end

  // stage 1: line store read data, write-back, window shift
  dogex_ram #(
    .WIDTH(WW),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .we   (s1_valid),
    .waddr(s1_addr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    word = s1_byp ? s1_byp_data : rdata;
    for (int l = 0; l < 3; l++) begin
      top[l] = word[l*LW+SB +: SB];
      mid[l] = word[l*LW +: SB];
      wdata[l*LW +: LW] = {mid[l], s1_samp[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < 3; l++) begin
        for (int p = 0; p < 3; p++) begin
          for (int q = 0; q < 3; q++) begin
            win[l][p][q] <= '0;
          end
        end
      end
    end else if (s1_valid) begin
      for (int l = 0; l < 3; l++) begin
        for (int p = 0; p < 3; p++) begin
          win[l][p][0] <= win[l][p][1];
          win[l][p][1] <= win[l][p][2];
        end
        win[l][0][2] <= top[l];
        win[l][1][2] <= mid[l];
        win[l][2][2] <= s1_samp[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_pos <= s1_pos;
    end
  end

  // stage 2: four candidate decisions over the clipped window
  logic [2:0] rowok;
  logic [2:0] colok;
  logic [3:0] key;
  logic [3:0] maxi;

  always_comb begin : decide
    logic signed [SB-1:0] v;
    logic signed [SB:0]   vx;
    logic [SB:0]          mag;
    logic                 pos;
    logic                 ext;
    logic                 nb;
    int                   rp;
    int                   cp;
    rowok = {1'b1, s2_pos.r_ge1, s2_pos.r_ge2};
    colok = {1'b1, s2_pos.c_ge1, s2_pos.c_ge2};
    for (int k = 0; k < 4; k++) begin
      rp  = 1 + (k >> 1);
      cp  = 1 + (k & 1);
      v   = win[1][rp][cp];
      pos = (v > 0);
      ext = 1'b1;
      for (int p = 0; p < 3; p++) begin
        for (int q = 0; q < 3; q++) begin
          for (int l = 0; l < 3; l++) begin
            nb = (p + 1 >= rp) && (p <= rp + 1) && (q + 1 >= cp) && (q <= cp + 1) &&
                 rowok[p] && colok[q] && !(l == 1 && p == rp && q == cp);
            if (nb && (pos ? (v < win[l][p][q]) : (v > win[l][p][q]))) begin
              ext = 1'b0;
            end
          end
        end
      end
      vx      = {v[SB-1], v};
      mag     = (v < 0) ? -vx : vx;
      key[k]  = (MW'(mag) > MW'(contrast_threshold)) && ext;
      maxi[k] = pos;
    end
  end

  always_comb begin
    push              = s2_valid && (s2_pos.r_ge1 || s2_pos.last_r) &&
                        (s2_pos.c_ge1 || s2_pos.last_c);
    push_entry.row    = s2_pos.row;
    push_entry.col    = s2_pos.col;
    push_entry.r_ge1  = s2_pos.r_ge1;
    push_entry.c_ge1  = s2_pos.c_ge1;
    push_entry.last_r = s2_pos.last_r;
    push_entry.last_c = s2_pos.last_c;
    push_entry.key    = key;
    push_entry.maxi   = maxi;
  end

  // bypass only arises when consecutive transfers hit the same column
  a_bypass_same_col: assert property (@(posedge clk) disable iff (rst)
    (accept && s1_valid && (s1_addr == raddr)) |-> (c_eff == '0))
    else $error("line store bypass on a column other than the first");

endmodule

// ===== rtl/dog_extremum_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dog_extremum_detector
// 3x3x3 scale-space extremum test over three difference-of-Gaussian layers.
// The first result passes the stage 1, stage 2, queue and output registers.
// Throughput: one pixel per cycle unless stalled; last-column extras (up to four
// results) and last-row pixels (two results each) drain via the 4-entry queue.
// Reset clears counters, window, queue and output and loads register defaults;
// the line store is not cleared (clipped reads only) and needs no sweep.
// ----------------------------------------------------------------------------
module dog_extremum_detector #(
  parameter int MAX_WIDTH   = dogex_pkg::MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = dogex_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [dogex_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dogex_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [SAMPLE_BITS-1:0]    dog_below,
  input  logic signed [SAMPLE_BITS-1:0]    dog_here,
  input  logic signed [SAMPLE_BITS-1:0]    dog_above,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [dogex_pkg::ROW_W-1:0]      pixel_row,
  output logic [dogex_pkg::COL_W-1:0]      pixel_col,
  output logic                             is_keypoint,
  output logic                             is_maximum,
  output logic                             last_of_run,
  output logic                             frame_done
);

  logic                        push;
  logic                        pop;
  dogex_pkg::entry_t           push_entry;
  dogex_pkg::entry_t           head;
  logic [dogex_pkg::QCNT_W-1:0] q_count;

  dogex_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .dog_below (dog_below),
    .dog_here  (dog_here),
    .dog_above (dog_above),
    .q_count   (q_count),
    .push      (push),
    .push_entry(push_entry)
  );

  dogex_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .count     (q_count)
  );

  dogex_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .count      (q_count),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_row  (pixel_row),
    .pixel_col  (pixel_col),
    .is_keypoint(is_keypoint),
    .is_maximum (is_maximum),
    .last_of_run(last_of_run),
    .frame_done (frame_done)
  );

endmodule
